// ===== rtl/core/wsd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_SECOND,
      PH_LEN16,
      PH_LEN64,
      PH_KEY,
      PH_DATA,
      PH_SKIP
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_RSV    = 2'd1,
      ERR_TRUNC  = 2'd2,
      ERR_TOOBIG = 2'd3
   } err_type;

   localparam logic [7:0] FIN_MASK    = 8'h80;
   localparam logic [7:0] RSV_MASK    = 8'h70;
   localparam logic [6:0] LEN_CODE16  = 7'd126;
   localparam logic [6:0] LEN_CODE64  = 7'd127;
   localparam logic [2:0] LEN16_LAST  = 3'd1;
   localparam logic [2:0] LEN64_LAST  = 3'd7;
   localparam logic [2:0] KEY_LAST    = 3'd3;

   typedef struct packed {
      kind_type    kind;
      logic        fin;
      logic [3:0]  opcode;
      logic        masked;
      logic [31:0] payload_length;
      logic [7:0]  payload_byte;
      logic        frame_end;
      logic [31:0] frame_byte_total;
      err_type     error_code;
   } result_type;

endpackage

// ===== rtl/core/wsd_parser.sv =====
// Frame parser: decode state and the per-byte result logic.
module wsd_parser #(
   parameter int LENGTH_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic [7:0]           step_byte,
   input  logic                 step_last,
   output logic                 res_valid,
   output wsd_pkg::result_type  res
);

   localparam int CW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

   wsd_pkg::phase_type     phase_ff, phase_in;
   logic                   fin_ff, fin_in;
   logic [3:0]             op_ff, op_in;
   logic                   mask_ff, mask_in;
   logic [LENGTH_BITS-1:0] acc_ff, acc_in;
   logic                   ovf_ff, ovf_in;
   logic [2:0]             fcnt_ff, fcnt_in;
   logic [31:0]            key_ff, key_in;
   logic [31:0]            idx_ff, idx_in;
   logic [31:0]            cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= wsd_pkg::PH_FIRST;
         fin_ff   <= 1'b0;
         op_ff    <= '0;
         mask_ff  <= 1'b0;
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
         fcnt_ff  <= '0;
         key_ff   <= '0;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         fin_ff   <= fin_in;
         op_ff    <= op_in;
         mask_ff  <= mask_in;
         acc_ff   <= acc_in;
         ovf_ff   <= ovf_in;
         fcnt_ff  <= fcnt_in;
         key_ff   <= key_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      logic              do_err;
      logic              do_frame;
      logic              done;
      logic              len_go;
      logic              hdr_go;
      logic              hdr_zero;
      wsd_pkg::err_type  err;
      wsd_pkg::kind_type kind;
      logic [7:0]        pbyte;
      logic [7:0]        key_byte;
      logic [6:0]        code7;
      logic [LENGTH_BITS-1:0] acc_shift;
      logic [31:0]       idx_next;

      phase_in = phase_ff;
      fin_in   = fin_ff;
      op_in    = op_ff;
      mask_in  = mask_ff;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      fcnt_in  = fcnt_ff;
      key_in   = key_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff + 32'd1;
      do_err   = 1'b0;
      do_frame = 1'b0;
      done     = 1'b0;
      len_go   = 1'b0;
      hdr_go   = 1'b0;
      hdr_zero = 1'b0;
      err      = wsd_pkg::ERR_NONE;
      kind     = wsd_pkg::KIND_HEADER;
      pbyte    = '0;
      code7    = step_byte[6:0];
      acc_shift = {acc_ff[LENGTH_BITS-9:0], step_byte};
      idx_next = idx_ff + 32'd1;
      case (idx_ff[1:0])
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase

      case (phase_ff)
         wsd_pkg::PH_FIRST: begin
            cnt_in  = 32'd1;
            fin_in  = |(step_byte & wsd_pkg::FIN_MASK);
            op_in   = step_byte[3:0];
            mask_in = 1'b0;
            acc_in  = '0;
            ovf_in  = 1'b0;
            fcnt_in = '0;
            key_in  = '0;
            idx_in  = '0;
            if (step_last) begin
               do_err = 1'b1;
               err    = wsd_pkg::ERR_TRUNC;
            end else if (|(step_byte & wsd_pkg::RSV_MASK)) begin
               do_err = 1'b1;
               err    = wsd_pkg::ERR_RSV;
            end else begin
               phase_in = wsd_pkg::PH_SECOND;
            end
         end
         wsd_pkg::PH_SECOND: begin
            mask_in = step_byte[7];
            fcnt_in = '0;
            if (code7 == wsd_pkg::LEN_CODE16 || code7 == wsd_pkg::LEN_CODE64) begin
               phase_in = (code7 == wsd_pkg::LEN_CODE16) ? wsd_pkg::PH_LEN16
                                                         : wsd_pkg::PH_LEN64;
               if (step_last) begin
                  do_err = 1'b1;
                  err    = wsd_pkg::ERR_TRUNC;
               end
            end else begin
               acc_in   = LENGTH_BITS'(code7);
               len_go   = 1'b1;
               hdr_zero = (code7 == 7'd0);
            end
         end
         wsd_pkg::PH_LEN16, wsd_pkg::PH_LEN64: begin
            acc_in = acc_shift;
            ovf_in = ovf_ff | (|acc_ff[LENGTH_BITS-1 -: 8]);
            if ((phase_ff == wsd_pkg::PH_LEN16 && fcnt_ff != wsd_pkg::LEN16_LAST) ||
                (phase_ff == wsd_pkg::PH_LEN64 && fcnt_ff != wsd_pkg::LEN64_LAST)) begin
               fcnt_in = fcnt_ff + 3'd1;
               if (step_last) begin
                  do_err = 1'b1;
                  err    = wsd_pkg::ERR_TRUNC;
               end
            end else begin
               fcnt_in = '0;
               if (ovf_in) begin
                  do_err = 1'b1;
                  err    = wsd_pkg::ERR_TOOBIG;
               end else begin
                  len_go   = 1'b1;
                  hdr_zero = (acc_shift == '0);
               end
            end
         end
         wsd_pkg::PH_KEY: begin
            key_in = {key_ff[23:0], step_byte};
            if (fcnt_ff != wsd_pkg::KEY_LAST) begin
               fcnt_in = fcnt_ff + 3'd1;
               if (step_last) begin
                  do_err = 1'b1;
                  err    = wsd_pkg::ERR_TRUNC;
               end
            end else begin
               fcnt_in  = '0;
               hdr_go   = 1'b1;
               hdr_zero = (acc_ff == '0);
            end
         end
         wsd_pkg::PH_DATA: begin
            pbyte  = mask_ff ? (step_byte ^ key_byte) : step_byte;
            idx_in = idx_next;
            kind   = wsd_pkg::KIND_DATA;
            if (CW'(idx_next) == CW'(acc_ff)) begin
               phase_in = wsd_pkg::PH_FIRST;
               do_frame = 1'b1;
               done     = 1'b1;
            end else if (step_last) begin
               do_err = 1'b1;
               err    = wsd_pkg::ERR_TRUNC;
            end else begin
               do_frame = 1'b1;
            end
         end
         wsd_pkg::PH_SKIP: begin
            cnt_in = cnt_ff;
            if (step_last) phase_in = wsd_pkg::PH_FIRST;
         end
         default: begin
            cnt_in   = cnt_ff;
            phase_in = wsd_pkg::PH_FIRST;
         end
      endcase

      // Length known: fetch the mask key or finish the header.
      if (len_go) begin
         if (mask_in) begin
            fcnt_in  = '0;
            phase_in = wsd_pkg::PH_KEY;
            if (step_last) begin
               do_err = 1'b1;
               err    = wsd_pkg::ERR_TRUNC;
            end
         end else begin
            hdr_go = 1'b1;
         end
      end

      if (hdr_go) begin
         kind = wsd_pkg::KIND_HEADER;
         if (hdr_zero) begin
            phase_in = wsd_pkg::PH_FIRST;
            do_frame = 1'b1;
            done     = 1'b1;
         end else if (step_last) begin
            do_err = 1'b1;
            err    = wsd_pkg::ERR_TRUNC;
         end else begin
            idx_in   = '0;
            phase_in = wsd_pkg::PH_DATA;
            do_frame = 1'b1;
         end
      end

      // Drop the rest of the buffer after a fatal header error.
      if (do_err) begin
         phase_in = (err == wsd_pkg::ERR_TRUNC || step_last) ? wsd_pkg::PH_FIRST
                                                             : wsd_pkg::PH_SKIP;
      end

      res_valid = do_err | do_frame;
      if (do_err) begin
         res            = '0;
         res.kind       = wsd_pkg::KIND_ERROR;
         res.error_code = err;
      end else begin
         res.kind             = kind;
         res.fin              = fin_in;
         res.opcode           = op_in;
         res.masked           = mask_in;
         res.payload_length   = 32'(acc_in);
         res.payload_byte     = pbyte;
         res.frame_end        = done;
         res.frame_byte_total = done ? cnt_in : 32'd0;
         res.error_code       = wsd_pkg::ERR_NONE;
      end
   end

   a_key_needs_mask: assert property (@(posedge clock) disable iff (reset)
      phase_ff == wsd_pkg::PH_KEY |-> mask_ff)
      else $error("key phase without mask flag");

   a_data_from_data_phase: assert property (@(posedge clock) disable iff (reset)
      step_en && res_valid && res.kind == wsd_pkg::KIND_DATA |-> phase_ff == wsd_pkg::PH_DATA)
      else $error("payload result outside data phase");

   a_len16_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == wsd_pkg::PH_LEN16 |-> fcnt_ff <= wsd_pkg::LEN16_LAST)
      else $error("16-bit length byte count out of range");

endmodule

// ===== rtl/core/websocket_frame_deframer.sv =====
// Top level of the WebSocket frame deframer: request register, parser, result register.
//
// Usage: feed the received buffer one byte per request on req_tdata, with req_tlast
// high on the last byte of the available buffer. Frames are decoded back to back.
// Each request yields at most one result on the rsp_ channel: a header result once
// the header (length and optional mask key) is complete, one result per payload
// byte with the mask removed, or an error (reserved bits set, buffer truncated,
// length wider than LENGTH_BITS). rsp_tlast marks the result that closes a frame
// and then carries the frame's total byte count.
// Path: a request waits in the input register; when the parser steps it, its result
// loads into the output register and shows on rsp_ until the receiver takes it.
// Throughput: one byte per cycle while the receiver takes results; a byte whose
// result cannot yet be stored waits in the input register.
// A request that yields no result advances even while a result waits.
// Reset (synchronous, active high) empties both registers and returns the parser
// to waiting for the first header byte.
// When the receiver stalls, the result register holds; the next request is still
// taken into the input register, and req_tready drops only when both are full.
module websocket_frame_deframer #(
   parameter int LENGTH_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // buffer_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] fin_bit, [4:1] frame_opcode, [5] masked, [37:6] payload_length,
   // [45:38] payload_byte, [77:46] frame_byte_total, [79:78] error_code
   output logic [79:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // [1:0] result_kind
   output logic        rsp_tlast    // frame_end
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_last_ff;
   logic                out_valid_ff, out_valid_in;
   wsd_pkg::result_type out_res_ff;
   logic                res_valid;
   wsd_pkg::result_type res;
   logic                advance;

   // Advance the held request when it yields no result or its result has somewhere to go.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready || !res_valid);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = (in_valid_ff && !advance) || (req_tvalid && req_tready);
   assign out_valid_in = (out_valid_ff && !rsp_tready) || (advance && res_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the request payload on acceptance.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Load a new result only when the parser steps and produces one.
   always_ff @(posedge clock) begin
      if (advance && res_valid) out_res_ff <= res;
   end

   wsd_parser #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .step_byte (in_byte_ff),
      .step_last (in_last_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.kind;
   assign rsp_tlast  = out_res_ff.frame_end;
   assign rsp_tdata  = {out_res_ff.error_code, out_res_ff.frame_byte_total,
                        out_res_ff.payload_byte, out_res_ff.payload_length,
                        out_res_ff.masked, out_res_ff.opcode, out_res_ff.fin};

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == wsd_pkg::KIND_ERROR |-> !rsp_tlast && rsp_tdata[77:0] == '0)
      else $error("error result carries frame fields");

   a_count_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[77:46] == 32'd0)
      else $error("byte count shown before frame end");

   a_request_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("held request lost or overwritten");

endmodule
